[rtl/wmft_pkg.sv]
// Package: shared constants and types for the window mode-frequency tracker.
`default_nettype none

package wmft_pkg;

  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned MAX_COUNT_W     = 17;
  localparam int unsigned VALUE_COUNT_DEF = 65536;
  localparam int unsigned WINDOW_MAX_DEF  = 65536;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_OCC,
    S_OLD,
    S_NEW,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/window_mode_frequency_tracker_top.sv]
// Top level: window mode-frequency tracker with a small sequencer over two RAMs.
//
//   channel | direction | signals                       | beat
//   in      | input     | in_valid_i/in_ready_o         | op_i, value_i
//   out     | output    | out_valid_o/out_ready_i       | max_count_o, error_o
//
// From accept to result register an item passes through a read of the
// per-value count RAM, then up to two read-modify-write steps on the tally RAM
// through its single read port. A rejected item skips both steps, and a removal
// that empties its value skips the second. Then the sequencer idles again.
// in_ready_o is high only while the sequencer idles.
// After reset both RAMs are swept to zero, one entry per cycle, over
// max(VALUE_COUNT, WINDOW_MAX + 1) entries with in_ready_o low.
// The result register lets the next item be taken while a result waits; an
// item that finishes while the previous result is still held stalls there.
`default_nettype none

module window_mode_frequency_tracker_top #(
  parameter int unsigned VALUE_COUNT = wmft_pkg::VALUE_COUNT_DEF,
  parameter int unsigned WINDOW_MAX  = wmft_pkg::WINDOW_MAX_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             op_i,
  input  wire logic [wmft_pkg::VALUE_W-1:0]     value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [wmft_pkg::MAX_COUNT_W-1:0] max_count_o,
  output logic                                  error_o
);

  import wmft_pkg::*;

  localparam int unsigned AW        = $clog2(VALUE_COUNT);
  localparam int unsigned TDEPTH    = WINDOW_MAX + 1;
  localparam int unsigned CW        = $clog2(TDEPTH);
  localparam int unsigned TW        = $clog2(VALUE_COUNT + 1);
  localparam int unsigned CLR_N     = (VALUE_COUNT > TDEPTH) ? VALUE_COUNT : TDEPTH;
  localparam int unsigned CLRW      = $clog2(CLR_N);

  state_e                 state_q, state_d;
  logic [CLRW-1:0]        clr_q, clr_d;
  op_e                    op_q, op_d;
  logic [VALUE_W-1:0]     value_q, value_d;
  logic [CW-1:0]          c_q, c_d;
  logic [CW-1:0]          cnew_q, cnew_d;
  logic [CW-1:0]          hi_q, hi_d;
  logic [CW-1:0]          win_q, win_d;
  logic                   item_err_q, item_err_d;
  logic                   out_valid_q, out_valid_d;
  logic [MAX_COUNT_W-1:0] max_q, max_d;
  logic                   err_q, err_d;

  logic                   occ_we;
  logic [AW-1:0]          occ_waddr, occ_raddr;
  logic [CW-1:0]          occ_wdata, occ_rdata;
  logic                   tal_we;
  logic [CW-1:0]          tal_waddr, tal_raddr;
  logic [TW-1:0]          tal_wdata, tal_rdata;

  logic [31:0]            value_i_ext, value_q_ext, hi_ext;
  logic                   range_err, add_err, rem_err;
  logic [TW-1:0]          tal_dec;

  assign value_i_ext = 32'(value_i);
  assign value_q_ext = 32'(value_q);
  assign hi_ext      = 32'(hi_q);

  assign range_err = value_q_ext >= 32'(VALUE_COUNT);
  assign add_err   = (32'(win_q) >= 32'(WINDOW_MAX)) || (32'(occ_rdata) >= 32'(WINDOW_MAX));
  assign rem_err   = (occ_rdata == '0);
  // tally never underflows: a zero entry stays zero
  assign tal_dec   = (tal_rdata != '0) ? tal_rdata - TW'(1) : tal_rdata;

  wmft_ram #(.WIDTH(CW), .DEPTH(VALUE_COUNT)) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (occ_raddr),
    .rdata_o (occ_rdata)
  );

  wmft_ram #(.WIDTH(TW), .DEPTH(TDEPTH)) u_tally_ram (
    .clk_i   (clk_i),
    .we_i    (tal_we),
    .waddr_i (tal_waddr),
    .wdata_i (tal_wdata),
    .raddr_i (tal_raddr),
    .rdata_o (tal_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      hi_q        <= '0;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hi_q        <= hi_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    value_q    <= value_d;
    c_q        <= c_d;
    cnew_q     <= cnew_d;
    item_err_q <= item_err_d;
    max_q      <= max_d;
    err_q      <= err_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    value_d     = value_q;
    c_d         = c_q;
    cnew_d      = cnew_q;
    hi_d        = hi_q;
    win_d       = win_q;
    item_err_d  = item_err_q;
    out_valid_d = out_valid_q;
    max_d       = max_q;
    err_d       = err_q;

    in_ready_o  = 1'b0;
    occ_we      = 1'b0;
    occ_waddr   = value_q_ext[AW-1:0];
    occ_wdata   = '0;
    occ_raddr   = value_i_ext[AW-1:0];
    tal_we      = 1'b0;
    tal_waddr   = c_q;
    tal_wdata   = '0;
    tal_raddr   = c_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        occ_we    = 32'(clr_q) < 32'(VALUE_COUNT);
        occ_waddr = clr_q[AW-1:0];
        tal_we    = 32'(clr_q) < 32'(TDEPTH);
        tal_waddr = clr_q[CW-1:0];
        if (32'(clr_q) == 32'(CLR_N - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + CLRW'(1);
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d    = op_e'(op_i);
          value_d = value_i;
          state_d = S_RD_OCC;
        end
      end
      S_RD_OCC: begin
        c_d       = occ_rdata;
        tal_raddr = occ_rdata;
        if (range_err || (op_q == OP_ADD && add_err) || (op_q == OP_REMOVE && rem_err)) begin
          item_err_d = 1'b1;
          state_d    = S_DONE;
        end else begin
          item_err_d = 1'b0;
          occ_we     = 1'b1;
          if (op_q == OP_ADD) begin
            cnew_d = occ_rdata + CW'(1);
            win_d  = win_q + CW'(1);
          end else begin
            cnew_d = occ_rdata - CW'(1);
            win_d  = win_q - CW'(1);
          end
          occ_wdata = cnew_d;
          state_d   = S_OLD;
        end
      end
      S_OLD: begin
        // tally[c] is on the read port; retire one value from count c
        tal_waddr = c_q;
        tal_wdata = tal_dec;
        tal_raddr = cnew_q;
        if (op_q == OP_ADD) begin
          tal_we  = (c_q != '0);
          state_d = S_NEW;
        end else begin
          tal_we = 1'b1;
          if (c_q == hi_q && tal_dec == '0) begin
            hi_d = hi_q - CW'(1);
          end
          state_d = (cnew_q == '0) ? S_DONE : S_NEW;
        end
      end
      S_NEW: begin
        tal_we    = 1'b1;
        tal_waddr = cnew_q;
        tal_wdata = tal_rdata + TW'(1);
        tal_raddr = cnew_q;
        if (op_q == OP_ADD && cnew_q > hi_q) begin
          hi_d = cnew_q;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          max_d       = hi_ext[MAX_COUNT_W-1:0];
          err_d       = item_err_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign max_count_o = max_q;
  assign error_o     = err_q;

endmodule

`default_nettype wire

[rtl/wmft_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wmft_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/wmft_checker.sv]
// Checker: port-level properties of the tracker, bound to the top level.
`default_nettype none

module wmft_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [wmft_pkg::MAX_COUNT_W-1:0] max_count_o,
  input wire logic                             error_o
);

  import wmft_pkg::*;

  logic [MAX_COUNT_W-1:0] last_max_q;
  logic                   out_fire;

  assign out_fire  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_max_q <= '0;
    end else if (out_fire) begin
      last_max_q <= max_count_o;
    end
  end

  // one item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("in_ready_o high right after an accepted beat");

  // a rejected item leaves the mode frequency untouched
  a_err_keeps_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (max_count_o == last_max_q))
    else $error("error beat changed max_count_o");

  // one item moves the maximum by at most one
  a_max_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((max_count_o == last_max_q) ||
                     (max_count_o == last_max_q + MAX_COUNT_W'(1)) ||
                     (max_count_o == last_max_q - MAX_COUNT_W'(1))))
    else $error("max_count_o stepped by more than one");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(max_count_o) && $stable(error_o)))
    else $error("output beat dropped or changed while stalled");

endmodule

bind window_mode_frequency_tracker_top wmft_checker u_wmft_checker (.*);

`default_nettype wire

[tb/sv/window_mode_frequency_tracker_top_test.sv]
// Testbench for the window mode-frequency tracker: directed table, random traffic, window drain.
`timescale 1ns / 100ps

module window_mode_frequency_tracker_top_test;
  import wmft_pkg::*;

  localparam int unsigned VALUE_COUNT = VALUE_COUNT_DEF;
  localparam int unsigned WINDOW_MAX  = WINDOW_MAX_DEF;
  localparam int unsigned RANDOM_ITEMS = 1200;

  typedef struct packed {
    logic [MAX_COUNT_W-1:0] max_count;
    logic                   err;
  } mode_result_t;

  typedef struct packed {
    op_e                    op;
    logic [VALUE_W-1:0]     value;
    logic                   typed;
    logic [MAX_COUNT_W-1:0] max_count;
    logic                   err;
  } stim_row_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic                   op_i        = 1'b0;
  logic [VALUE_W-1:0]     value_i     = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [MAX_COUNT_W-1:0] max_count_o;
  logic                   error_o;

  // shadow of the block's stores
  int unsigned value_hits [VALUE_COUNT];
  int unsigned hit_tally  [WINDOW_MAX+1];
  int unsigned mode_freq   = 0;
  int unsigned window_fill = 0;

  mode_result_t pending_modes [$];
  int unsigned  mismatch_count = 0;
  bit           idling_on      = 1'b1;

  // typed rows: after reset, obvious counts, error codes
  stim_row_t dir_rows [22] = '{
    '{OP_REMOVE, 16'h0000, 1'b1, 17'd0, 1'b1},
    '{OP_ADD,    16'h0000, 1'b1, 17'd1, 1'b0},
    '{OP_ADD,    16'hFFFF, 1'b1, 17'd1, 1'b0},
    '{OP_ADD,    16'hFFFF, 1'b1, 17'd2, 1'b0},
    '{OP_REMOVE, 16'h1234, 1'b1, 17'd2, 1'b1},
    '{OP_ADD,    16'hAAAA, 1'b0, 17'd0, 1'b0},
    '{OP_ADD,    16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_ADD,    16'hAAAA, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'hFFFF, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'hAAAA, 1'b0, 17'd0, 1'b0},
    '{OP_ADD,    16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_ADD,    16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'h0000, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'h0000, 1'b1, 17'd3, 1'b1},
    '{OP_REMOVE, 16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'h5555, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'hFFFF, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'hAAAA, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'hAAAA, 1'b0, 17'd0, 1'b0},
    '{OP_ADD,    16'h8001, 1'b0, 17'd0, 1'b0},
    '{OP_REMOVE, 16'h7FFE, 1'b0, 17'd0, 1'b0}
  };

  window_mode_frequency_tracker_top #(
    .VALUE_COUNT(VALUE_COUNT),
    .WINDOW_MAX (WINDOW_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .max_count_o(max_count_o),
    .error_o    (error_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic mode_result_t track_mode(input op_e op, input logic [VALUE_W-1:0] value);
    mode_result_t res;
    int unsigned  c;
    res.err = 1'b0;
    if (int'(value) >= VALUE_COUNT) begin
      res.err = 1'b1;
    end else begin
      c = value_hits[value];
      if (op == OP_ADD) begin
        if (window_fill >= WINDOW_MAX || c >= WINDOW_MAX) begin
          res.err = 1'b1;
        end else begin
          if (c != 0) hit_tally[c] = hit_tally[c] - 1;
          c = c + 1;
          value_hits[value] = c;
          hit_tally[c] = hit_tally[c] + 1;
          window_fill = window_fill + 1;
          if (c > mode_freq) mode_freq = c;
        end
      end else begin
        if (c == 0 || c > WINDOW_MAX) begin
          res.err = 1'b1;
        end else begin
          if (hit_tally[c] != 0) hit_tally[c] = hit_tally[c] - 1;
          // last holder of the maximum leaves: mode drops by one
          if (c == mode_freq && hit_tally[c] == 0) mode_freq = mode_freq - 1;
          c = c - 1;
          value_hits[value] = c;
          if (c != 0) hit_tally[c] = hit_tally[c] + 1;
          if (window_fill != 0) window_fill = window_fill - 1;
        end
      end
    end
    res.max_count = mode_freq[MAX_COUNT_W-1:0];
    return res;
  endfunction

  // valid stays high across back-to-back beats; it only drops for a gap
  task automatic send_beat(input op_e op, input logic [VALUE_W-1:0] value, input logic typed,
                           input logic [MAX_COUNT_W-1:0] typed_max, input logic typed_err);
    mode_result_t res;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    res = track_mode(op, value);
    if (typed) begin
      res.max_count = typed_max;
      res.err       = typed_err;
    end
    pending_modes = {pending_modes, res};
  endtask

  task automatic wait_drained();
    while (pending_modes.size() != 0) @(posedge clk_i);
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    mode_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_modes.size() == 0) begin
        $error("unexpected beat: max_count %0d error %0b", max_count_o, error_o);
        mismatch_count++;
      end else begin
        exp_res = pending_modes.pop_front();
        if (max_count_o !== exp_res.max_count) begin
          $error("max_count: expected %0d, actual %0d", exp_res.max_count, max_count_o);
          mismatch_count++;
        end
        if (error_o !== exp_res.err) begin
          $error("error: expected %0b, actual %0b", exp_res.err, error_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [VALUE_W-1:0] pool [8];
    logic [VALUE_W-1:0] pick;
    logic [VALUE_W-1:0] fill_val;
    int unsigned        r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      send_beat(dir_rows[i].op, dir_rows[i].value, dir_rows[i].typed,
                dir_rows[i].max_count, dir_rows[i].err);
    end

    foreach (pool[i]) pool[i] = 16'($urandom);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) idling_on = ($urandom_range(0, 4) != 0);
      if (n % 150 == 149) foreach (pool[i]) pool[i] = 16'($urandom);
      if (n == RANDOM_ITEMS / 2) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        send_beat(op_e'($urandom_range(0, 1)), 16'($urandom), 1'b0, '0, 1'b0);
      end else if (r < 62) begin
        send_beat(OP_ADD, pool[$urandom_range(0, 7)], 1'b0, '0, 1'b0);
      end else begin
        // mostly removals of values actually present
        pick = pool[$urandom_range(0, 7)];
        for (int t = 0; t < 4 && value_hits[pick] == 0; t++) pick = pool[$urandom_range(0, 7)];
        send_beat(OP_REMOVE, pick, 1'b0, '0, 1'b0);
      end
    end

    // empty the window; the mode frequency is back to zero afterwards
    idling_on = 1'b0;
    for (int v = 0; v < VALUE_COUNT; v++) begin
      while (value_hits[v] != 0) send_beat(OP_REMOVE, 16'(v), 1'b0, '0, 1'b0);
    end
    fill_val = 16'($urandom);
    send_beat(OP_REMOVE, fill_val, 1'b1, 17'd0, 1'b1);
    send_beat(OP_ADD,    fill_val, 1'b1, 17'd1, 1'b0);
    send_beat(OP_ADD,    fill_val, 1'b1, 17'd2, 1'b0);
    send_beat(OP_REMOVE, fill_val, 1'b1, 17'd1, 1'b0);
    send_beat(OP_REMOVE, fill_val, 1'b0, '0, 1'b0);

    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("window_mode_frequency_tracker_top regression: pass");
    end else begin
      $display("window_mode_frequency_tracker_top regression: fail");
    end
    $finish;
  end

  initial begin
    #(64'd25_000_000);
    $display("window_mode_frequency_tracker_top regression: fail");
    $finish;
  end

endmodule

[window_mode_frequency_tracker_top.f]
rtl/wmft_pkg.sv
rtl/wmft_ram.sv
rtl/window_mode_frequency_tracker_top.sv
rtl/wmft_checker.sv
tb/sv/window_mode_frequency_tracker_top_test.sv
